// File: rtl/sequence_symbol_histogram_core_assert.svh
// Assertion helpers shared by the RTL. All checks sample on clk_i and are
// switched off while rst_ni is low.
`ifndef SEQUENCE_SYMBOL_HISTOGRAM_CORE_ASSERT_SVH
`define SEQUENCE_SYMBOL_HISTOGRAM_CORE_ASSERT_SVH

// Same-cycle implication.
`define SSH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssh assertion failed");

// Next-cycle implication.
`define SSH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssh assertion failed");

`endif

// File: rtl/ssh_pkg.sv
package ssh_pkg;

  localparam int COUNT_BITS     = 32;
  localparam int NUM_BINS       = 23;
  localparam int BIN_BITS       = 5;
  localparam int OUT_COUNT_BITS = 32;

  localparam logic [BIN_BITS-1:0] DNA_LEN     = 5'd4;
  localparam logic [BIN_BITS-1:0] PROTEIN_LEN = 5'd21;
  localparam logic [BIN_BITS-1:0] BINARY_LEN  = 5'd2;

  localparam logic [7:0] DNA_LETTERS [4] = '{"A", "C", "G", "T"};
  localparam logic [7:0] PROTEIN_LETTERS [21] = '{
    "A", "C", "D", "E", "F", "G", "H", "I", "K", "L", "M",
    "N", "P", "Q", "R", "S", "T", "V", "W", "Y", "X"
  };
  localparam logic [7:0] BINARY_LETTERS [2] = '{"0", "1"};

  localparam logic [7:0] GAP_RESET     = 8'd45;
  localparam logic [7:0] MISSING_RESET = 8'd63;

  typedef enum logic [1:0] {
    FUNC_COUNT   = 2'd0,
    FUNC_END_SEQ = 2'd1,
    FUNC_REPORT  = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_DNA     = 2'd0,
    MODE_PROTEIN = 2'd1,
    MODE_BINARY  = 2'd2
  } alpha_mode_e;

  typedef enum logic [1:0] {
    REG_ALPHABET_MODE  = 2'd0,
    REG_GAP_SYMBOL     = 2'd1,
    REG_MISSING_SYMBOL = 2'd2,
    REG_PER_SEQUENCE   = 2'd3
  } reg_addr_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] gap_symbol;
    logic [7:0] missing_symbol;
    logic       per_sequence_output;
  } cfg_t;

  typedef struct packed {
    logic                inc;
    logic                clr;
    logic [BIN_BITS-1:0] bin;
  } bank_ctrl_t;

  typedef struct packed {
    func_e      func;
    logic [7:0] symbol;
  } in_beat_t;

  typedef struct packed {
    logic [BIN_BITS-1:0]       bin_index;
    logic [OUT_COUNT_BITS-1:0] bin_count;
    logic                      run_is_cumulative;
    logic                      last_of_run;
  } out_beat_t;

  // Letters of the selected alphabet; the reserved mode code falls back to DNA.
  function automatic logic [BIN_BITS-1:0] alpha_len(input logic [1:0] mode);
    logic [BIN_BITS-1:0] len;
    unique case (mode)
      MODE_PROTEIN: len = PROTEIN_LEN;
      MODE_BINARY:  len = BINARY_LEN;
      default:      len = DNA_LEN;
    endcase
    return len;
  endfunction

  function automatic logic [BIN_BITS-1:0] num_bins(input logic [1:0] mode);
    return alpha_len(mode) + 5'd2;
  endfunction

endpackage

// File: rtl/ssh_stream_if.sv
interface ssh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/ssh_cfg_regs.sv
module ssh_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ssh_pkg::cfg_t cfg_o
);

  ssh_pkg::cfg_t      cfg_q, cfg_d;
  ssh_pkg::reg_addr_e sel;
  logic               wr_en;

  assign sel    = ssh_pkg::reg_addr_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        ssh_pkg::REG_ALPHABET_MODE:  cfg_d.mode                = pwdata[1:0];
        ssh_pkg::REG_GAP_SYMBOL:     cfg_d.gap_symbol          = pwdata[7:0];
        ssh_pkg::REG_MISSING_SYMBOL: cfg_d.missing_symbol      = pwdata[7:0];
        ssh_pkg::REG_PER_SEQUENCE:   cfg_d.per_sequence_output = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      ssh_pkg::REG_ALPHABET_MODE:  prdata = {30'd0, cfg_q.mode};
      ssh_pkg::REG_GAP_SYMBOL:     prdata = {24'd0, cfg_q.gap_symbol};
      ssh_pkg::REG_MISSING_SYMBOL: prdata = {24'd0, cfg_q.missing_symbol};
      ssh_pkg::REG_PER_SEQUENCE:   prdata = {31'd0, cfg_q.per_sequence_output};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode                <= ssh_pkg::MODE_DNA;
      cfg_q.gap_symbol          <= ssh_pkg::GAP_RESET;
      cfg_q.missing_symbol      <= ssh_pkg::MISSING_RESET;
      cfg_q.per_sequence_output <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/ssh_bin_match.sv
module ssh_bin_match (
  input  logic [7:0]                   symbol_i,
  input  ssh_pkg::cfg_t                cfg_i,
  output logic [ssh_pkg::BIN_BITS-1:0] bin_o
);

  logic [7:0]                   folded;
  logic [ssh_pkg::BIN_BITS-1:0] len;
  logic [ssh_pkg::BIN_BITS-1:0] bin;

  assign len = ssh_pkg::alpha_len(cfg_i.mode);

  // Walk the letters from the top down so the lowest matching bin wins.
  // The gap symbol is compared against the folded character as written.
  always_comb begin
    folded = (symbol_i >= 8'h61 && symbol_i <= 8'h7A) ? symbol_i - 8'd32 : symbol_i;
    bin = len + 5'd1;
    if (folded == cfg_i.gap_symbol) begin
      bin = len;
    end
    unique case (cfg_i.mode)
      ssh_pkg::MODE_PROTEIN: begin
        for (int i = 20; i >= 0; i--) begin
          if (ssh_pkg::PROTEIN_LETTERS[i] == folded) bin = 5'(i);
        end
      end
      ssh_pkg::MODE_BINARY: begin
        for (int i = 1; i >= 0; i--) begin
          if (ssh_pkg::BINARY_LETTERS[i] == folded) bin = 5'(i);
        end
      end
      default: begin
        for (int i = 3; i >= 0; i--) begin
          if (ssh_pkg::DNA_LETTERS[i] == folded) bin = 5'(i);
        end
      end
    endcase
  end

  assign bin_o = bin;

endmodule

// File: rtl/ssh_counter_bank.sv
module ssh_counter_bank #(
  parameter int COUNT_BITS = ssh_pkg::COUNT_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ssh_pkg::bank_ctrl_t          ctrl_i,
  input  logic [ssh_pkg::BIN_BITS-1:0] rd_idx_i,
  output logic [COUNT_BITS-1:0]        rd_count_o
);

  logic [COUNT_BITS-1:0] count_q [ssh_pkg::NUM_BINS];

  for (genvar g = 0; g < ssh_pkg::NUM_BINS; g++) begin : g_cell
    logic [COUNT_BITS-1:0] count_d;
    logic                  hit;

    assign hit = ctrl_i.inc && (ctrl_i.bin == 5'(g));

    // Saturating increment: an all-ones counter stays put.
    always_comb begin
      count_d = count_q[g];
      if (ctrl_i.clr) begin
        count_d = '0;
      end else if (hit && (count_q[g] != {COUNT_BITS{1'b1}})) begin
        count_d = count_q[g] + 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        count_q[g] <= '0;
      end else begin
        count_q[g] <= count_d;
      end
    end
  end

  assign rd_count_o = (rd_idx_i < 5'(ssh_pkg::NUM_BINS)) ? count_q[rd_idx_i] : '0;

`include "sequence_symbol_histogram_core_assert.svh"

  `SSH_ASSERT_NXT(a_clear_zeroes_bank, ctrl_i.clr, count_q[0] == '0)

endmodule

// File: rtl/sequence_symbol_histogram_core.sv
// Sequence symbol histogram. Characters enter one per beat on in_i and are
// counted into bins of the alphabet chosen by the APB registers, followed by
// the gap and missing bins. A count, clear or end-of-sequence item with
// per-sequence output off never stalls the input, so a stream of them runs at one
// item per clock. A report item, and an end-of-sequence item with per-sequence
// output on, sends a run of n beats on out_o (n is 6 for DNA, 23 for protein,
// 4 for binary). It stays in the input register until its last beat is
// loaded into the single output register, one beat per cycle, and the input
// stalls until then; back-pressure on out_o stretches the run.
// The counters are flip-flops cleared at reset, so no clearing pass follows.
module sequence_symbol_histogram_core #(
  parameter int COUNT_BITS = ssh_pkg::COUNT_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ssh_stream_if.sink    in_i,
  ssh_stream_if.source  out_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  ssh_pkg::cfg_t       cfg;
  ssh_pkg::bank_ctrl_t total_ctrl, seq_ctrl;

  logic                         in_valid_q;
  ssh_pkg::func_e               in_func_q;
  logic [7:0]                   in_sym_q;
  logic                         in_ready;
  logic [ssh_pkg::BIN_BITS-1:0] bin;
  logic [ssh_pkg::BIN_BITS-1:0] nbins;
  logic [ssh_pkg::BIN_BITS-1:0] run_idx_q, run_idx_d;
  logic                         is_count, is_report, is_end_seq, is_clear;
  logic                         run_item, run_last, run_fire, in_done, out_load_ok;
  logic [COUNT_BITS-1:0]        total_rd, seq_rd, run_count;
  logic [ssh_pkg::OUT_COUNT_BITS-1:0] run_count_clamped;

  logic                         out_valid_q;
  ssh_pkg::out_beat_t           out_q;

  ssh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssh_bin_match u_match (
    .symbol_i (in_sym_q),
    .cfg_i    (cfg),
    .bin_o    (bin)
  );

  assign is_count   = in_valid_q && (in_func_q == ssh_pkg::FUNC_COUNT);
  assign is_end_seq = in_valid_q && (in_func_q == ssh_pkg::FUNC_END_SEQ);
  assign is_report  = in_valid_q && (in_func_q == ssh_pkg::FUNC_REPORT);
  assign is_clear   = in_valid_q && (in_func_q == ssh_pkg::FUNC_CLEAR);

  assign nbins       = ssh_pkg::num_bins(cfg.mode);
  assign run_item    = is_report || (is_end_seq && cfg.per_sequence_output);
  assign run_last    = (run_idx_q == nbins - 5'd1);
  assign out_load_ok = !out_valid_q || out_o.ready;
  assign run_fire    = run_item && out_load_ok;
  // A run item stays in the input register until its last beat is loaded.
  assign in_done     = in_valid_q && (!run_item || (run_fire && run_last));
  assign in_ready    = !in_valid_q || in_done;
  assign in_i.ready  = in_ready;

  assign total_ctrl.inc = is_count;
  assign total_ctrl.clr = is_clear;
  assign total_ctrl.bin = bin;
  assign seq_ctrl.inc   = is_count && cfg.per_sequence_output;
  assign seq_ctrl.clr   = is_end_seq && in_done;
  assign seq_ctrl.bin   = bin;

  ssh_counter_bank #(.COUNT_BITS(COUNT_BITS)) u_total (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (total_ctrl),
    .rd_idx_i   (run_idx_q),
    .rd_count_o (total_rd)
  );

  ssh_counter_bank #(.COUNT_BITS(COUNT_BITS)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (seq_ctrl),
    .rd_idx_i   (run_idx_q),
    .rd_count_o (seq_rd)
  );

  assign run_count = is_report ? total_rd : seq_rd;

  if (COUNT_BITS > ssh_pkg::OUT_COUNT_BITS) begin : g_clamp
    assign run_count_clamped = (|run_count[COUNT_BITS-1:ssh_pkg::OUT_COUNT_BITS]) ?
                               {ssh_pkg::OUT_COUNT_BITS{1'b1}} :
                               run_count[ssh_pkg::OUT_COUNT_BITS-1:0];
  end else begin : g_extend
    assign run_count_clamped = ssh_pkg::OUT_COUNT_BITS'(run_count);
  end

  always_comb begin
    run_idx_d = run_idx_q;
    if (run_fire) begin
      run_idx_d = run_last ? '0 : run_idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      run_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      run_idx_q <= run_idx_d;
      if (run_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_func_q <= in_i.payload.func;
      in_sym_q  <= in_i.payload.symbol;
    end
    if (run_fire) begin
      out_q.bin_index         <= run_idx_q;
      out_q.bin_count         <= run_count_clamped;
      out_q.run_is_cumulative <= is_report;
      out_q.last_of_run       <= run_last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`include "sequence_symbol_histogram_core_assert.svh"

  `SSH_ASSERT_IMP(a_run_idx_range, 1'b1, run_idx_q < nbins)
  `SSH_ASSERT_NXT(a_run_holds_item, run_item && !(run_fire && run_last), in_valid_q)
  `SSH_ASSERT_NXT(a_last_beat_flag, run_fire && run_last, out_valid_q && out_q.last_of_run)

endmodule
